// ===== design/gpfit_pkg.sv =====
// Package for the grid plane fit block: item types, controller/datapath
// command and status types, the determinant microprogram and its helpers.
// No dependencies.
package gpfit_pkg;

  // Fixed widths of the arithmetic.
  localparam int ACC_W       = 56;   // accumulator width
  localparam int BIG_W       = 136;  // determinant and division width
  localparam int CNT_W       = 18;   // valid cell count width
  localparam int U_W         = 12;   // centered half-cell coordinate width
  localparam int H_W         = 24;   // height width
  localparam int SLOPE_W     = 32;
  localparam int OFF_W       = 24;
  localparam int PCNT_W      = 17;
  localparam int CFG_W       = 16;
  localparam int CFG_AW      = 2;
  localparam int MIN_POINTS  = 3;
  localparam int SLOPE_SHIFT = 17;   // 2 * 65536
  localparam int UCODE_LEN   = 21;
  localparam int PC_W        = $clog2(UCODE_LEN);

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_NUM_COLS  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_CELL_SIZE = 2'd2;

  typedef struct packed {
    logic signed [H_W-1:0] height;
    logic                  cell_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope_x;
    logic signed [SLOPE_W-1:0] slope_y;
    logic signed [OFF_W-1:0]   offset;
    logic                      fit_ok;
    logic [PCNT_W-1:0]         point_count;
  } out_item_t;

  // Accumulator selects for the multiplier operand.
  typedef enum logic [3:0] {
    SEL_XX, SEL_XY, SEL_X, SEL_YY, SEL_Y, SEL_N, SEL_XZ, SEL_YZ, SEL_Z
  } sel_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE, OP_LD, OP_MUL, OP_SUB, OP_DSET, OP_DSUB, OP_DADD,
    OP_MULCS, OP_DIVX, OP_DIVY, OP_DIVC, OP_LOADOUT
  } op_t;

  typedef struct packed {
    logic       take;   // an input item is accepted this cycle
    op_t        op;
    logic       dst;    // 0: T0, 1: T1
    sel_t       sel;
    logic [1:0] dk;     // determinant slot
    logic       ok;     // fit result flag for the output load
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic last;
    logic cnt_ok;
    logic d_zero;
    logic out_free;
  } dp_stat_t;

  // One microprogram step: operation, target register, matrix row, column.
  typedef struct packed {
    op_t        op;
    logic       dst;
    logic [1:0] r;
    logic [1:0] c;
  } uop_t;

  // Cofactor expansion of a 3x3 determinant along the first row.
  localparam uop_t UCODE [UCODE_LEN] = '{
    '{OP_LD,   1'b0, 2'd1, 2'd1}, '{OP_MUL,  1'b0, 2'd2, 2'd2},
    '{OP_LD,   1'b1, 2'd1, 2'd2}, '{OP_MUL,  1'b1, 2'd2, 2'd1},
    '{OP_SUB,  1'b0, 2'd0, 2'd0}, '{OP_MUL,  1'b0, 2'd0, 2'd0},
    '{OP_DSET, 1'b0, 2'd0, 2'd0},
    '{OP_LD,   1'b0, 2'd1, 2'd0}, '{OP_MUL,  1'b0, 2'd2, 2'd2},
    '{OP_LD,   1'b1, 2'd1, 2'd2}, '{OP_MUL,  1'b1, 2'd2, 2'd0},
    '{OP_SUB,  1'b0, 2'd0, 2'd0}, '{OP_MUL,  1'b0, 2'd0, 2'd1},
    '{OP_DSUB, 1'b0, 2'd0, 2'd0},
    '{OP_LD,   1'b0, 2'd1, 2'd0}, '{OP_MUL,  1'b0, 2'd2, 2'd1},
    '{OP_LD,   1'b1, 2'd1, 2'd1}, '{OP_MUL,  1'b1, 2'd2, 2'd0},
    '{OP_SUB,  1'b0, 2'd0, 2'd0}, '{OP_MUL,  1'b0, 2'd0, 2'd2},
    '{OP_DADD, 1'b0, 2'd0, 2'd0}
  };

  // Element (r, c) of the normal matrix for determinant k. Determinant 0 is
  // the matrix itself; determinant k replaces column k-1 by the right side.
  function automatic sel_t elem_sel(logic [1:0] k, logic [1:0] r, logic [1:0] c);
    sel_t s;
    s = SEL_N;
    if (k != 2'd0 && c == k - 2'd1) begin
      case (r)
        2'd0:    s = SEL_XZ;
        2'd1:    s = SEL_YZ;
        default: s = SEL_Z;
      endcase
    end else begin
      case ({r, c})
        4'b0000: s = SEL_XX;
        4'b0001: s = SEL_XY;
        4'b0010: s = SEL_X;
        4'b0100: s = SEL_XY;
        4'b0101: s = SEL_YY;
        4'b0110: s = SEL_Y;
        4'b1000: s = SEL_X;
        4'b1001: s = SEL_Y;
        default: s = SEL_N;
      endcase
    end
    return s;
  endfunction

endpackage

// ===== design/gpfit_ctrl.sv =====
// Controller of the grid plane fit: accepts cells, then sequences the
// determinant microprogram, the scale multiply and the three divisions.
// Depends on gpfit_pkg.
module gpfit_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gpfit_pkg::dp_stat_t stat,
  output gpfit_pkg::dp_cmd_t  cmd
);
  import gpfit_pkg::*;

  typedef enum logic [7:0] {
    S_ACC   = 8'b00000001,
    S_START = 8'b00000010,
    S_DET   = 8'b00000100,
    S_DWAIT = 8'b00001000,
    S_TEST  = 8'b00010000,
    S_SOLVE = 8'b00100000,
    S_SWAIT = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t          state, state_next;
  logic [PC_W-1:0] pc, pc_next;
  logic [1:0]      k, k_next;
  logic [1:0]      st, st_next;
  logic            ok, ok_next;
  logic            accept;
  uop_t            uop;

  assign in_ready = (state == S_ACC);
  assign accept   = in_valid && in_ready;
  assign uop      = UCODE[pc];

  // Next state and command decode.
  always_comb begin
    state_next = state;
    pc_next    = pc;
    k_next     = k;
    st_next    = st;
    ok_next    = ok;
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.sel    = SEL_N;
    cmd.take   = accept;
    cmd.dk     = k;
    cmd.ok     = ok;
    case (state)
      S_ACC: begin
        if (accept && stat.last) state_next = S_START;
      end
      S_START: begin
        pc_next = '0;
        k_next  = 2'd0;
        if (stat.cnt_ok) begin
          state_next = S_DET;
        end else begin
          ok_next    = 1'b0;
          state_next = S_OUT;
        end
      end
      S_DET: begin
        cmd.op     = uop.op;
        cmd.dst    = uop.dst;
        cmd.sel    = elem_sel(k, uop.r, uop.c);
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat.busy) begin
          state_next = S_DET;
          if (pc == PC_W'(UCODE_LEN - 1)) begin
            pc_next = '0;
            if (k == 2'd3) state_next = S_TEST;
            else k_next = k + 2'd1;
          end else begin
            pc_next = pc + PC_W'(1);
          end
        end
      end
      S_TEST: begin
        st_next = 2'd0;
        if (stat.d_zero) begin
          ok_next    = 1'b0;
          state_next = S_OUT;
        end else begin
          ok_next    = 1'b1;
          state_next = S_SOLVE;
        end
      end
      S_SOLVE: begin
        case (st)
          2'd0:    cmd.op = OP_MULCS;
          2'd1:    cmd.op = OP_DIVX;
          2'd2:    cmd.op = OP_DIVY;
          default: cmd.op = OP_DIVC;
        endcase
        state_next = S_SWAIT;
      end
      S_SWAIT: begin
        if (!stat.busy) begin
          if (st == 2'd3) begin
            state_next = S_OUT;
          end else begin
            st_next    = st + 2'd1;
            state_next = S_SOLVE;
          end
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.op     = OP_LOADOUT;
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
      pc    <= '0;
      k     <= 2'd0;
      st    <= 2'd0;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      k     <= k_next;
      st    <= st_next;
      ok    <= ok_next;
    end
  end

endmodule

// ===== design/gpfit_dp.sv =====
// Datapath of the grid plane fit: configuration registers, grid position,
// the nine sums, a bit-serial multiplier, a restoring divider and the
// output register. Depends on gpfit_pkg.
module gpfit_dp #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [gpfit_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [gpfit_pkg::CFG_W-1:0]     cfg_wdata,
  input  gpfit_pkg::in_item_t             in_data,
  input  gpfit_pkg::dp_cmd_t              cmd,
  output gpfit_pkg::dp_stat_t             stat,
  output logic                            out_valid,
  input  logic                            out_ready,
  output gpfit_pkg::out_item_t            out_data
);
  import gpfit_pkg::*;

  localparam int RPW   = $clog2(MAX_ROWS);
  localparam int CPW   = $clog2(MAX_COLS);
  localparam int DW    = 10;
  localparam int MCW   = $clog2(ACC_W);
  localparam int DCW   = $clog2(BIG_W);

  localparam logic [1:0] MT_T0  = 2'd0;
  localparam logic [1:0] MT_T1  = 2'd1;
  localparam logic [1:0] MT_DEN = 2'd2;
  localparam logic [1:0] DT_X   = 2'd0;
  localparam logic [1:0] DT_Y   = 2'd1;
  localparam logic [1:0] DT_C   = 2'd2;

  logic [8:0]  num_rows, num_cols, rows_eff, cols_eff;
  logic [15:0] cell_size, cs_eff;
  logic [RPW-1:0] row_pos;
  logic [CPW-1:0] col_pos;
  logic signed [ACC_W-1:0] acc_xx, acc_xy, acc_x, acc_yy, acc_y, acc_xz, acc_yz, acc_z;
  logic [CNT_W-1:0] cnt;

  logic signed [U_W-1:0]     u, v;
  logic signed [2*U_W-1:0]   p_uu, p_uv, p_vv;
  logic signed [U_W+H_W-1:0] p_uz, p_vz;
  logic last, cfg_hit, clear;

  logic signed [BIG_W-1:0] t0, t1, den;
  logic signed [BIG_W-1:0] dreg [4];
  logic signed [ACC_W-1:0] opnd;

  logic                    mul_busy;
  logic [MCW-1:0]          mul_cnt;
  logic signed [BIG_W-1:0] mul_mc, mul_acc, mul_add, mul_sum;
  logic [ACC_W-1:0]        mul_mr;
  logic [1:0]              mul_tgt;

  logic                    div_busy, div_sat, div_neg;
  logic [DCW-1:0]          div_cnt;
  logic [BIG_W-1:0]        div_n, div_d, div_rem, div_q;
  logic [BIG_W:0]          rem_sh;
  logic [1:0]              div_tgt;
  logic signed [BIG_W-1:0] dnum, dden, an, ad;
  logic [BIG_W-1:0]        lim, mag, sval;

  logic signed [SLOPE_W-1:0] res_sx, res_sy;
  logic signed [OFF_W-1:0]   res_off;

  // Grid size and cell size as used.
  always_comb begin
    if (num_rows == 9'd0)                rows_eff = 9'd1;
    else if (int'(num_rows) > MAX_ROWS)  rows_eff = 9'(MAX_ROWS);
    else                                 rows_eff = num_rows;
    if (num_cols == 9'd0)                cols_eff = 9'd1;
    else if (int'(num_cols) > MAX_COLS)  cols_eff = 9'(MAX_COLS);
    else                                 cols_eff = num_cols;
    cs_eff = (cell_size == 16'd0) ? 16'd1 : cell_size;
  end

  // Centered coordinates in half-cell units and the per-cell products.
  assign u    = $signed(U_W'({col_pos, 1'b0}) - U_W'(cols_eff) + U_W'(1));
  assign v    = $signed(U_W'({row_pos, 1'b0}) - U_W'(rows_eff) + U_W'(1));
  assign p_uu = u * u;
  assign p_uv = u * v;
  assign p_vv = v * v;
  assign p_uz = u * in_data.height;
  assign p_vz = v * in_data.height;
  assign last = (DW'(row_pos) == DW'(rows_eff) - DW'(1)) &&
                (DW'(col_pos) == DW'(cols_eff) - DW'(1));

  assign cfg_hit = cfg_we && (cfg_addr == REG_NUM_ROWS || cfg_addr == REG_NUM_COLS ||
                              cfg_addr == REG_CELL_SIZE);
  assign clear   = cfg_hit || (cmd.op == OP_LOADOUT);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= 9'd256;
      num_cols  <= 9'd256;
      cell_size <= 16'd3277;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUM_ROWS:  num_rows  <= cfg_wdata[8:0];
        REG_NUM_COLS:  num_cols  <= cfg_wdata[8:0];
        REG_CELL_SIZE: cell_size <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Grid position and the least-squares sums.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_pos <= '0;
      col_pos <= '0;
      acc_xx  <= '0;
      acc_xy  <= '0;
      acc_x   <= '0;
      acc_yy  <= '0;
      acc_y   <= '0;
      acc_xz  <= '0;
      acc_yz  <= '0;
      acc_z   <= '0;
      cnt     <= '0;
    end else if (cmd.take) begin
      if (last) begin
        row_pos <= '0;
        col_pos <= '0;
      end else if (DW'(col_pos) + DW'(1) >= DW'(cols_eff)) begin
        col_pos <= '0;
        row_pos <= row_pos + RPW'(1);
      end else begin
        col_pos <= col_pos + CPW'(1);
      end
      if (in_data.cell_valid) begin
        acc_xx <= acc_xx + ACC_W'(p_uu);
        acc_xy <= acc_xy + ACC_W'(p_uv);
        acc_x  <= acc_x + ACC_W'(u);
        acc_yy <= acc_yy + ACC_W'(p_vv);
        acc_y  <= acc_y + ACC_W'(v);
        acc_xz <= acc_xz + ACC_W'(p_uz);
        acc_yz <= acc_yz + ACC_W'(p_vz);
        acc_z  <= acc_z + ACC_W'(in_data.height);
        cnt    <= cnt + CNT_W'(1);
      end
    end
  end

  // Multiplier operand select.
  always_comb begin
    case (cmd.sel)
      SEL_XX:  opnd = acc_xx;
      SEL_XY:  opnd = acc_xy;
      SEL_X:   opnd = acc_x;
      SEL_YY:  opnd = acc_yy;
      SEL_Y:   opnd = acc_y;
      SEL_XZ:  opnd = acc_xz;
      SEL_YZ:  opnd = acc_yz;
      SEL_Z:   opnd = acc_z;
      default: opnd = ACC_W'(cnt);
    endcase
  end

  // One multiplier bit per cycle; the top bit of the two's complement
  // operand carries negative weight.
  always_comb begin
    if (!mul_mr[0])                        mul_add = '0;
    else if (mul_cnt == MCW'(ACC_W - 1))   mul_add = -mul_mc;
    else                                   mul_add = mul_mc;
    mul_sum = mul_acc + mul_add;
  end

  // Division operands, rounding setup and output saturation.
  always_comb begin
    case (cmd.op)
      OP_DIVX: begin
        dnum = dreg[1] <<< SLOPE_SHIFT;
        dden = den;
      end
      OP_DIVY: begin
        dnum = dreg[2] <<< SLOPE_SHIFT;
        dden = den;
      end
      default: begin
        dnum = dreg[3];
        dden = dreg[0];
      end
    endcase
    an     = dnum[BIG_W-1] ? -dnum : dnum;
    ad     = dden[BIG_W-1] ? -dden : dden;
    rem_sh = {div_rem, div_n[BIG_W-1]};
    lim    = (div_tgt == DT_C) ? (BIG_W'(1) << (OFF_W - 1)) : (BIG_W'(1) << (SLOPE_W - 1));
    if (!div_neg) lim = lim - BIG_W'(1);
    mag    = (div_q > lim) ? lim : div_q;
    sval   = div_neg ? -mag : mag;
  end

  // Wide registers, multiplier and divider.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      div_busy <= 1'b0;
      div_sat  <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LD: begin
          if (cmd.dst) t1 <= BIG_W'(opnd);
          else         t0 <= BIG_W'(opnd);
        end
        OP_MUL: begin
          mul_mc   <= cmd.dst ? t1 : t0;
          mul_mr   <= opnd;
          mul_acc  <= '0;
          mul_cnt  <= '0;
          mul_tgt  <= cmd.dst ? MT_T1 : MT_T0;
          mul_busy <= 1'b1;
        end
        OP_MULCS: begin
          mul_mc   <= dreg[0];
          mul_mr   <= ACC_W'(cs_eff);
          mul_acc  <= '0;
          mul_cnt  <= '0;
          mul_tgt  <= MT_DEN;
          mul_busy <= 1'b1;
        end
        OP_SUB:  t0 <= t0 - t1;
        OP_DSET: dreg[cmd.dk] <= t0;
        OP_DSUB: dreg[cmd.dk] <= dreg[cmd.dk] - t0;
        OP_DADD: dreg[cmd.dk] <= dreg[cmd.dk] + t0;
        OP_DIVX, OP_DIVY, OP_DIVC: begin
          div_n    <= (an <<< 1) + ad;
          div_d    <= ad <<< 1;
          div_neg  <= dnum[BIG_W-1] ^ dden[BIG_W-1];
          div_rem  <= '0;
          div_q    <= '0;
          div_cnt  <= '0;
          div_sat  <= 1'b0;
          div_busy <= 1'b1;
          div_tgt  <= (cmd.op == OP_DIVX) ? DT_X : ((cmd.op == OP_DIVY) ? DT_Y : DT_C);
        end
        default: ;
      endcase

      // Shift-add step.
      if (mul_busy) begin
        mul_acc <= mul_sum;
        mul_mc  <= mul_mc <<< 1;
        mul_mr  <= mul_mr >> 1;
        mul_cnt <= mul_cnt + MCW'(1);
        if (mul_cnt == MCW'(ACC_W - 1)) begin
          mul_busy <= 1'b0;
          case (mul_tgt)
            MT_T0:   t0  <= mul_sum;
            MT_T1:   t1  <= mul_sum;
            default: den <= mul_sum;
          endcase
        end
      end

      // Restoring division steps, then a saturation step that writes the result.
      if (div_busy && !div_sat) begin
        if (rem_sh >= {1'b0, div_d}) begin
          div_rem <= BIG_W'(rem_sh - {1'b0, div_d});
          div_q   <= {div_q[BIG_W-2:0], 1'b1};
        end else begin
          div_rem <= rem_sh[BIG_W-1:0];
          div_q   <= {div_q[BIG_W-2:0], 1'b0};
        end
        div_n   <= div_n << 1;
        div_cnt <= div_cnt + DCW'(1);
        if (div_cnt == DCW'(BIG_W - 1)) div_sat <= 1'b1;
      end else if (div_busy) begin
        div_busy <= 1'b0;
        div_sat  <= 1'b0;
        case (div_tgt)
          DT_X:    res_sx  <= sval[SLOPE_W-1:0];
          DT_Y:    res_sy  <= sval[SLOPE_W-1:0];
          default: res_off <= sval[OFF_W-1:0];
        endcase
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_LOADOUT) begin
      out_valid            <= 1'b1;
      out_data.fit_ok      <= cmd.ok;
      out_data.point_count <= cnt[PCNT_W-1:0];
      out_data.slope_x     <= cmd.ok ? res_sx : '0;
      out_data.slope_y     <= cmd.ok ? res_sy : '0;
      out_data.offset      <= cmd.ok ? res_off : '0;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.busy     = mul_busy || div_busy;
  assign stat.last     = last;
  assign stat.cnt_ok   = (cnt >= CNT_W'(MIN_POINTS));
  assign stat.d_zero   = (dreg[0] == '0);
  assign stat.out_free = !out_valid || out_ready;

endmodule

// ===== design/grid_plane_least_squares_fit.sv =====
// Least-squares plane fit over a raster height grid: one cell per cycle is
// taken while the controller waits for cells; after its last cell the solve
// runs four determinants of nine serial multiplies and twelve other steps
// each, one scale multiply and three divisions, and no cell of the next grid
// is taken until the result is in the output register, which may wait on
// the receiver. Synchronous reset clears control and sums.
module grid_plane_least_squares_fit #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  gpfit_pkg::in_item_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output gpfit_pkg::out_item_t         out_data,
  input  logic                         cfg_we,
  input  logic [gpfit_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [gpfit_pkg::CFG_W-1:0]  cfg_wdata
);
  import gpfit_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  gpfit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Sums, arithmetic units and output register.
  gpfit_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/gpfit_checker.sv =====
// Port-level checks for the grid plane fit and the bind that attaches them.
// Depends on gpfit_pkg and grid_plane_least_squares_fit.
module gpfit_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input gpfit_pkg::out_item_t         out_data
);
  import gpfit_pkg::*;

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item pending after reset");

  // A failed fit reports zero coefficients.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.fit_ok |->
      out_data.slope_x == 0 && out_data.slope_y == 0 && out_data.offset == 0)
    else $error("failed fit with nonzero coefficients");

  // Input stops only after an item has been taken.
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input ready dropped without an accepted item");

endmodule

bind grid_plane_least_squares_fit gpfit_checker u_gpfit_checker (.*);

// ===== sim/grid_plane_least_squares_fit_tb.sv =====
// Testbench for grid_plane_least_squares_fit: streams height grids through the
// block and checks every plane fit against an exact wide-integer predictor.
// Depends on gpfit_pkg and the grid_plane_least_squares_fit RTL.
`timescale 1ns / 1ps

module grid_plane_least_squares_fit_tb;
  import gpfit_pkg::*;

  typedef logic signed [255:0] wide_t;

  localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;  // unmapped index
  localparam int GRID_MAX   = 256;
  localparam int IDLE_WAIT  = 3000;   // longer than one solve
  localparam int STALL_LIMIT = 40000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  // Predictor state.
  int unsigned rows_reg, cols_reg, csize_reg;
  longint s_uu, s_uv, s_u, s_vv, s_v, s_uz, s_vz, s_z;
  int unsigned n_valid, row_at, col_at;
  out_item_t   fit_queue[$];

  int  err_count = 0;
  int  items_sent = 0;
  int  burst_left = 0;
  int  idle_cycles = 0;
  logic in_took = 1'b0;

  grid_plane_least_squares_fit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Grid predictor helpers.
  function automatic int unsigned eff_size(int unsigned v);
    if (v == 0) return 1;
    return (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

  function automatic wide_t det3(wide_t a11, wide_t a12, wide_t a13, wide_t a21, wide_t a22,
                                 wide_t a23, wide_t a31, wide_t a32, wide_t a33);
    return a11 * (a22 * a33 - a23 * a32) - a12 * (a21 * a33 - a23 * a31)
         + a13 * (a21 * a32 - a22 * a31);
  endfunction

  // Rounds num/den to nearest, halves away from zero, and saturates to bits.
  function automatic longint round_sat(wide_t num, wide_t den, int bits);
    logic  neg;
    wide_t an, ad, q, lim;
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = (2 * an + ad) / (2 * ad);
    lim = (wide_t'(1) <<< (bits - 1)) - (neg ? 0 : 1);
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic void clear_sums();
    s_uu = 0; s_uv = 0; s_u = 0; s_vv = 0; s_v = 0;
    s_uz = 0; s_vz = 0; s_z = 0;
    n_valid = 0; row_at = 0; col_at = 0;
  endfunction

  // Folds one accepted cell into the sums and queues a fit on the last cell.
  function automatic void predict_cell(in_item_t c);
    int unsigned rows, cols;
    longint      u, v, z;
    wide_t       d, dp, dq, dc, den, n;
    out_item_t   r;
    logic        last;
    rows = eff_size(rows_reg);
    cols = eff_size(cols_reg);
    if (row_at >= rows || col_at >= cols) clear_sums();
    if (c.cell_valid) begin
      z = longint'(c.height);
      u = 2 * longint'(col_at) - (longint'(cols) - 1);
      v = 2 * longint'(row_at) - (longint'(rows) - 1);
      s_uu += u * u; s_uv += u * v; s_u += u; s_vv += v * v; s_v += v;
      s_uz += u * z; s_vz += v * z; s_z += z;
      n_valid++;
    end
    last = (row_at == rows - 1) && (col_at == cols - 1);
    if (col_at + 1 >= cols) begin
      col_at = 0;
      row_at++;
    end else begin
      col_at++;
    end
    if (!last) return;
    r = '0;
    r.point_count = PCNT_W'(n_valid);
    if (n_valid >= MIN_POINTS) begin
      n = wide_t'(n_valid);
      d = det3(s_uu, s_uv, s_u, s_uv, s_vv, s_v, s_u, s_v, n);
      if (d != 0) begin
        dp  = det3(s_uz, s_uv, s_u, s_vz, s_vv, s_v, s_z, s_v, n);
        dq  = det3(s_uu, s_uz, s_u, s_uv, s_vz, s_v, s_u, s_z, n);
        dc  = det3(s_uu, s_uv, s_uz, s_uv, s_vv, s_vz, s_u, s_v, s_z);
        den = d * wide_t'((csize_reg == 0) ? 1 : csize_reg);
        r.slope_x = SLOPE_W'(round_sat(dp * 131072, den, SLOPE_W));
        r.slope_y = SLOPE_W'(round_sat(dq * 131072, den, SLOPE_W));
        r.offset  = OFF_W'(round_sat(dc, d, OFF_W));
        r.fit_ok  = 1'b1;
      end
    end
    fit_queue.insert(fit_queue.size(), r);
    clear_sums();
  endfunction

  // Acceptance flag and watchdog, sampled at the rising edge.
  always @(posedge clk) begin
    in_took <= in_valid && in_ready;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles > STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Compares each accepted fit with the oldest expected one.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (fit_queue.size() == 0) begin
        $error("unexpected fit result %p", out_data);
        err_count++;
      end else begin
        e = fit_queue.pop_front();
        if (out_data.slope_x !== e.slope_x) begin
          $error("slope_x expected %0d actual %0d", e.slope_x, out_data.slope_x);
          err_count++;
        end
        if (out_data.slope_y !== e.slope_y) begin
          $error("slope_y expected %0d actual %0d", e.slope_y, out_data.slope_y);
          err_count++;
        end
        if (out_data.offset !== e.offset) begin
          $error("offset expected %0d actual %0d", e.offset, out_data.offset);
          err_count++;
        end
        if (out_data.fit_ok !== e.fit_ok) begin
          $error("fit_ok expected %0d actual %0d", e.fit_ok, out_data.fit_ok);
          err_count++;
        end
        if (out_data.point_count !== e.point_count) begin
          $error("point_count expected %0d actual %0d", e.point_count, out_data.point_count);
          err_count++;
        end
      end
    end
  end

  // Receiver backpressure: the mode is redrawn at random times.
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(50, 400)) begin
        @(negedge clk);
        case (mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          2: out_ready = ($urandom_range(0, 7) == 0);
          default: out_ready = ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Sends one cell; called and returns at a falling edge.
  task automatic send_cell(logic signed [H_W-1:0] h, logic vld);
    in_item_t c;
    c.height = h;
    c.cell_valid = vld;
    in_valid = 1'b1;
    in_data = c;
    do @(negedge clk); while (!in_took);
    predict_cell(c);
    items_sent++;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Waits until every fit is out and the block has gone quiet.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (fit_queue.size() != 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  // The input channel stays idle across the write so no item is taken twice.
  task automatic write_reg(logic [CFG_AW-1:0] idx, int unsigned val);
    in_valid = 1'b0;
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = CFG_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_NUM_ROWS:  rows_reg = val & 'h1FF;
      REG_NUM_COLS:  cols_reg = val & 'h1FF;
      REG_CELL_SIZE: csize_reg = val & 'hFFFF;
      default: return;
    endcase
    clear_sums();
  endtask

  task automatic set_grid(int unsigned r, int unsigned c, int unsigned cs);
    wait_idle();
    write_reg(REG_NUM_ROWS, r);
    write_reg(REG_NUM_COLS, c);
    write_reg(REG_CELL_SIZE, cs);
  endtask

  function automatic logic signed [H_W-1:0] rand_height();
    return H_W'($urandom_range(0, 'hFFFFFF));
  endfunction

  // Extremes of height, missing points, single-row (singular) and clamped grids.
  task automatic test_directed();
    set_grid(2, 2, 1);
    send_cell(24'sh7FFFFF, 1'b1); send_cell(-24'sh800000, 1'b1);
    send_cell(-24'sh800000, 1'b1); send_cell(24'sh7FFFFF, 1'b1);
    send_cell(24'sh7FFFFF, 1'b1); send_cell(24'sh7FFFFF, 1'b0);
    send_cell(24'sh000000, 1'b1); send_cell(-24'sh800000, 1'b0);
    set_grid(1, 3, 'hFFFF);
    send_cell(24'sd100, 1'b1); send_cell(-24'sd5, 1'b1); send_cell(24'sh555555, 1'b1);
    set_grid(0, 511, 3277);
    repeat (3) send_cell(rand_height(), 1'b1);
    write_reg(REG_SPARE, 'hFFFF);
    repeat (GRID_MAX - 3) send_cell(rand_height(), 1'b1);
  endtask

  // A grid cut short by a register write must be discarded.
  task automatic test_partial_grid();
    set_grid(3, 3, 65535);
    repeat (5) send_cell(rand_height(), 1'b1);
    set_grid(3, 3, 2);
    repeat (9) send_cell(rand_height(), 1'b1);
  endtask

  // Random grid shapes, scales, height styles and masks.
  task automatic test_random(int target);
    int unsigned r, c, cs, ncell, pick;
    int     style, keep;
    longint base, gx, gy, h;
    while (items_sent < target) begin
      pick = $urandom_range(0, 19);
      r = $urandom_range(2, 6);
      c = $urandom_range(2, 6);
      if (pick == 0) begin
        r = 256; c = $urandom_range(1, 2);
      end else if (pick == 1) begin
        r = 1; c = 256;
      end else if (pick == 2) begin
        r = $urandom_range(0, 1) ? 0 : $urandom_range(257, 511);
        c = 0;
      end else if (pick == 3) begin
        c = $urandom_range(0, 1) ? 1 : $urandom_range(257, 511);
        r = 1;
      end
      case ($urandom_range(0, 3))
        0: cs = 1;
        1: cs = 65535;
        2: cs = 0;
        default: cs = $urandom_range(1, 65535);
      endcase
      if (pick == 2 || pick == 3) cs = $urandom_range(1, 65535);
      set_grid(r, c, cs);
      ncell = eff_size(r) * eff_size(c);
      repeat ($urandom_range(1, 4)) begin
        if (items_sent < target) begin
          style = $urandom_range(0, 2);
          keep  = $urandom_range(0, 3);
          base  = longint'($urandom_range(0, 'hFFFFF)) - 524288;
          gx    = longint'($urandom_range(0, 'h1FFFF)) - 65536;
          gy    = longint'($urandom_range(0, 'h1FFFF)) - 65536;
          for (int i = 0; i < ncell; i++) begin
            if (style == 0) begin
              h = $signed(rand_height());
            end else if (style == 1) begin
              h = base + gx * (i % eff_size(c)) + gy * (i / eff_size(c))
                + $signed($urandom_range(0, 63)) - 32;
              if (h > 8388607) h = 8388607;
              if (h < -8388608) h = -8388608;
            end else begin
              h = $urandom_range(0, 1) ? 8388607 : -8388608;
            end
            case (keep)
              0: send_cell(H_W'(h), 1'b1);
              1: send_cell(H_W'(h), $urandom_range(0, 9) != 0);
              2: send_cell(H_W'(h), $urandom_range(0, 2) == 0);
              default: send_cell(H_W'(h), 1'($urandom_range(0, 1)));
            endcase
          end
        end
      end
      // Sometimes leave a partial grid behind for the next write to drop.
      if (items_sent < target && $urandom_range(0, 5) == 0)
        repeat ($urandom_range(1, ncell)) send_cell(rand_height(), 1'b1);
    end
  endtask

  initial begin
    rows_reg = 256;
    cols_reg = 256;
    csize_reg = 3277;
    clear_sums();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_partial_grid();
    test_random(1400);
    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== grid_plane_least_squares_fit.f =====
design/gpfit_pkg.sv
design/gpfit_ctrl.sv
design/gpfit_dp.sv
design/grid_plane_least_squares_fit.sv
design/gpfit_checker.sv
sim/grid_plane_least_squares_fit_tb.sv
